/* design/bc_pkg.sv */
// Shared types, constants and the reciprocal table for the bit crusher.
`timescale 1ns / 1ps

package bc_pkg;

    // Default number of voices with a held store entry
    localparam int VOICES_DEF = 8;

    // Field widths of the item and the configuration port
    localparam int VOICE_W  = 3;
    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 18;
    localparam int COUNT_W  = 24;

    // Phase counter limits (Q16)
    localparam logic [COUNT_W-1:0] ONE_Q16   = 24'd65536;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

    // Depth limits and the top bit position that the depth counts from
    localparam int DEPTH_MAX = 24;
    localparam int KEEP_TOP  = 26;

    // Configuration register indexes
    localparam logic [1:0] CFG_RATE_FRACTION = 2'd0;
    localparam logic [1:0] CFG_RATE_MOD_GAIN = 2'd1;
    localparam logic [1:0] CFG_BIT_DEPTH     = 2'd2;
    localparam logic [1:0] CFG_BITS_MOD_GAIN = 2'd3;

    // Configuration register set
    typedef struct packed {
        logic        [16:0] rate_fraction;
        logic signed [17:0] rate_mod_gain;
        logic        [4:0]  bit_depth;
        logic signed [17:0] bits_mod_gain;
    } cfg_t;

    // Rounded 2^24 / depth, depth 1..24
    function automatic logic [24:0] inv_depth(input logic [4:0] depth);
        logic [24:0] val;
        unique case (depth)
            5'd1:    val = 25'd16777216;
            5'd2:    val = 25'd8388608;
            5'd3:    val = 25'd5592405;
            5'd4:    val = 25'd4194304;
            5'd5:    val = 25'd3355443;
            5'd6:    val = 25'd2796203;
            5'd7:    val = 25'd2396745;
            5'd8:    val = 25'd2097152;
            5'd9:    val = 25'd1864135;
            5'd10:   val = 25'd1677722;
            5'd11:   val = 25'd1525201;
            5'd12:   val = 25'd1398101;
            5'd13:   val = 25'd1290555;
            5'd14:   val = 25'd1198373;
            5'd15:   val = 25'd1118481;
            5'd16:   val = 25'd1048576;
            5'd17:   val = 25'd986895;
            5'd18:   val = 25'd932068;
            5'd19:   val = 25'd883011;
            5'd20:   val = 25'd838861;
            5'd21:   val = 25'd798915;
            5'd22:   val = 25'd762601;
            5'd23:   val = 25'd729444;
            5'd24:   val = 25'd699051;
            default: val = 25'd0;
        endcase
        return val;
    endfunction

endpackage

/* design/bc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bc_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, hold data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/bc_phase.sv */
// Shared phase counter: rate increment, clamp and hold trigger.
`timescale 1ns / 1ps

module bc_phase
    import bc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  cfg_t               cfg,
    input  logic signed [31:0] rate_cv,
    output logic               latch
);

    logic [COUNT_W-1:0] phase_reg;
    logic [COUNT_W-1:0] phase_next;
    logic signed [49:0] rate_prod;
    logic signed [25:0] rate_adj;
    logic signed [27:0] sum;
    logic [COUNT_W-1:0] clamped;

    // Scale the control value, floor by 2^24
    assign rate_prod = $signed(cfg.rate_mod_gain) * $signed(rate_cv);
    assign rate_adj  = rate_prod[49:24];

    assign sum = 28'($signed({1'b0, phase_reg}))
               + 28'($signed({1'b0, cfg.rate_fraction}))
               + 28'(rate_adj);

    // Clamp to the counter range
    always_comb
    begin
        if (sum[27])
        begin
            clamped = '0;
        end
        else if (sum > 28'(COUNT_MAX))
        begin
            clamped = COUNT_MAX;
        end
        else
        begin
            clamped = sum[COUNT_W-1:0];
        end
    end

    // Wrap past 1.0 and flag a hold
    assign latch      = (clamped > ONE_Q16);
    assign phase_next = latch ? (clamped - ONE_Q16) : clamped;

    // Advance once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

/* design/bc_quant.sv */
// Active depth, bit clearing, reciprocal offset and saturation of the held sample.
`timescale 1ns / 1ps

module bc_quant
    import bc_pkg::*;
(
    input  cfg_t               cfg,
    input  logic signed [31:0] bits_cv,
    input  logic [31:0]        held,
    output logic [31:0]        sample_out
);

    logic signed [49:0] bits_prod;
    logic signed [51:0] total;
    logic [11:0]        depth_hi;
    logic [4:0]         depth;
    logic [4:0]         shift;
    logic [31:0]        mask;
    logic [31:0]        kept;
    logic signed [32:0] res;

    // Depth in Q40 before truncation
    assign bits_prod = $signed(cfg.bits_mod_gain) * $signed(bits_cv);
    assign total     = $signed({7'b0, cfg.bit_depth, 40'b0}) + 52'(bits_prod);
    assign depth_hi  = total[51:40];

    // Truncate and saturate to 1..24
    always_comb
    begin
        if (total[51] || (depth_hi == 12'd0))
        begin
            depth = 5'd1;
        end
        else if (depth_hi > 12'(DEPTH_MAX))
        begin
            depth = 5'(DEPTH_MAX);
        end
        else
        begin
            depth = depth_hi[4:0];
        end
    end

    // Clear the bits below the active depth
    assign shift = 5'(KEEP_TOP) - depth;
    assign mask  = (32'd1 << shift) - 32'd1;
    assign kept  = held & ~mask;

    // Add the offset, saturate at the top
    assign res = 33'($signed(kept)) + 33'($signed({1'b0, inv_depth(depth)}));
    assign sample_out = (!res[32] && res[31]) ? 32'h7FFFFFFF : res[31:0];

endmodule

/* design/audio_bit_crusher_unit.sv */
// Bit crusher top level: handshakes, configuration, held store and result register.
// Pipeline: an accepted item waits in the input register and moves into the result
// register once that is free or being taken; one item per cycle while out_stall is low.
// The phase counter update is a feedback loop through the phase register in the input-to-result stage.
// Reset: configuration returns to 65536, 0, 24, 0, the phase counter to zero and
// every held entry reads as zero until written, through a valid bit per voice.
`timescale 1ns / 1ps

module audio_bit_crusher_unit
    import bc_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // input item channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         voice,
    input  logic signed [31:0] sample_in,
    input  logic signed [31:0] rate_cv,
    input  logic signed [31:0] bits_cv,
    // result item channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] sample_out,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [17:0]        cfg_data
);

    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;

    cfg_t cfg_reg;

    logic              s1_valid_reg;
    logic [2:0]        s1_voice_reg;
    logic [31:0]       s1_sample_reg;
    logic signed [31:0] s1_rate_cv_reg;
    logic signed [31:0] s1_bits_cv_reg;
    logic              s1_byp_reg;
    logic [31:0]       s1_byp_data_reg;
    logic              s1_ent_vld_reg;

    logic              out_valid_reg;
    logic [31:0]       sample_out_reg;

    logic [VOICES-1:0] vld_reg;

    logic              out_ready;
    logic              fire;
    logic              s1_ready;
    logic              accept;
    logic              latch;
    logic              we;
    logic              in_range_in;
    logic              s1_in_range;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    logic [31:0]       ram_rdata;
    logic [31:0]       held_store;
    logic [31:0]       held;
    logic [31:0]       quant_out;

    // Handshake control
    assign out_ready = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && out_ready;
    assign s1_ready  = !s1_valid_reg || fire;
    assign accept    = in_valid && s1_ready;
    assign in_stall  = !s1_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_fraction <= 17'd65536;
            cfg_reg.rate_mod_gain <= '0;
            cfg_reg.bit_depth     <= 5'd24;
            cfg_reg.bits_mod_gain <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RATE_FRACTION: cfg_reg.rate_fraction <= cfg_data[16:0];
                CFG_RATE_MOD_GAIN: cfg_reg.rate_mod_gain <= $signed(cfg_data);
                CFG_BIT_DEPTH:     cfg_reg.bit_depth     <= cfg_data[4:0];
                CFG_BITS_MOD_GAIN: cfg_reg.bits_mod_gain <= $signed(cfg_data);
            endcase
        end
    end

    // Voice addressing
    assign in_range_in = (32'(voice) < VOICES);
    assign s1_in_range = (32'(s1_voice_reg) < VOICES);
    assign raddr       = AW'(voice);
    assign waddr       = AW'(s1_voice_reg);
    assign we          = fire && latch && s1_in_range;

    // Held sample store
    bc_ram #(
        .WIDTH (32),
        .DEPTH (VOICES),
        .ADDR_W(AW)
    ) u_held (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(s1_sample_reg),
        .re   (accept),
        .raddr(raddr),
        .rdata(ram_rdata)
    );

    // Entry valid bits, set on first write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (we)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // Input register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register: payload, with bypass of a write landing on the same edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_voice_reg    <= voice;
            s1_sample_reg   <= sample_in;
            s1_rate_cv_reg  <= rate_cv;
            s1_bits_cv_reg  <= bits_cv;
            s1_byp_reg      <= we && in_range_in && (waddr == raddr);
            s1_byp_data_reg <= s1_sample_reg;
            s1_ent_vld_reg  <= in_range_in && vld_reg[raddr];
        end
    end

    // Phase counter
    bc_phase u_phase (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .cfg    (cfg_reg),
        .rate_cv(s1_rate_cv_reg),
        .latch  (latch)
    );

    // Select the held value this item sees
    always_comb
    begin
        if (s1_byp_reg)
        begin
            held_store = s1_byp_data_reg;
        end
        else if (s1_ent_vld_reg)
        begin
            held_store = ram_rdata;
        end
        else
        begin
            held_store = '0;
        end
    end

    always_comb
    begin
        if (!s1_in_range)
        begin
            held = '0;
        end
        else if (latch)
        begin
            held = s1_sample_reg;
        end
        else
        begin
            held = held_store;
        end
    end

    // Quantiser
    bc_quant u_quant (
        .cfg       (cfg_reg),
        .bits_cv   (s1_bits_cv_reg),
        .held      (held),
        .sample_out(quant_out)
    );

    // Result register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            sample_out_reg <= quant_out;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = $signed(sample_out_reg);

endmodule

/* dv/audio_bit_crusher_unit_tb.sv */
// Self-checking testbench for the bit crusher: directed corner items, then randomised traffic.
`timescale 1ns / 1ps

module audio_bit_crusher_unit_tb
    import bc_pkg::*;
();

    typedef struct {
        logic [VOICE_W-1:0]         voice;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [31:0]         rate_cv;
        logic signed [31:0]         bits_cv;
    } crush_item_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [VOICE_W-1:0]         voice = '0;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic signed [31:0]         rate_cv = '0;
    logic signed [31:0]         bits_cv = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;

    // Mirror of the block's registers and state
    cfg_t                       crush_cfg;
    logic [COUNT_W-1:0]         phase_acc;
    logic [SAMPLE_W-1:0]        held_store [0:VOICES_DEF-1];

    // Crushed samples still to come out, oldest first
    logic signed [SAMPLE_W-1:0] crushed_queue [$];
    logic signed [SAMPLE_W-1:0] due_sample;
    int                         bad_results = 0;
    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;

    audio_bit_crusher_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .voice      (voice),
        .sample_in  (sample_in),
        .rate_cv    (rate_cv),
        .bits_cv    (bits_cv),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Advance the phase counter, latch the voice if it wraps, crush the held value
    function automatic logic signed [31:0] crush_sample(input crush_item_t it);
        longint      acc;
        longint      total;
        longint      res;
        int          depth;
        logic [31:0] held;
        logic [31:0] mask;
        acc = longint'(phase_acc) + longint'(crush_cfg.rate_fraction)
            + ((longint'(crush_cfg.rate_mod_gain) * longint'(it.rate_cv)) >>> 24);
        if (acc < 0)
            acc = 0;
        if (acc > longint'(COUNT_MAX))
            acc = longint'(COUNT_MAX);
        // strictly above 1.0: wrap and take a new sample
        if (acc > longint'(ONE_Q16))
        begin
            acc = acc - longint'(ONE_Q16);
            if (it.voice < VOICES_DEF)
                held_store[it.voice] = it.sample;
        end
        phase_acc = acc[COUNT_W-1:0];
        held = (it.voice < VOICES_DEF) ? held_store[it.voice] : '0;

        // depth is floored and held to 1..24
        total = (longint'(crush_cfg.bit_depth) <<< 40)
              + longint'(crush_cfg.bits_mod_gain) * longint'(it.bits_cv);
        if (total < (longint'(1) <<< 40))
            depth = 1;
        else
        begin
            depth = int'(total >>> 40);
            if (depth > DEPTH_MAX)
                depth = DEPTH_MAX;
        end
        mask = (32'd1 << (KEEP_TOP - depth)) - 32'd1;

        // add the rounded reciprocal of the depth, saturate upwards only
        res = longint'($signed(held & ~mask)) + (64'sd16777216 + depth / 2) / depth;
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        return res[31:0];
    endfunction

    task automatic note_bad(input string what, input logic [31:0] want, input logic [31:0] got);
        bad_results++;
        if (bad_results <= 10)
            $display("%s: expected %h, got %h", what, want, got);
    endtask

    // Send one item after a random idle gap, record its crushed sample on acceptance
    task automatic send_item(input logic [2:0] v, input logic [31:0] smp,
                             input logic [31:0] rcv, input logic [31:0] bcv);
        crush_item_t it;
        it.voice   = v;
        it.sample  = smp;
        it.rate_cv = rcv;
        it.bits_cv = bcv;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        voice     <= it.voice;
        sample_in <= it.sample;
        rate_cv   <= it.rate_cv;
        bits_cv   <= it.bits_cv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        crushed_queue.push_back(crush_sample(it));
    endtask

    // Hold the sender until every result has left, then let the pipeline settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (crushed_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_RATE_FRACTION: crush_cfg.rate_fraction = data[16:0];
            CFG_RATE_MOD_GAIN: crush_cfg.rate_mod_gain = $signed(data);
            CFG_BIT_DEPTH:     crush_cfg.bit_depth     = data[4:0];
            CFG_BITS_MOD_GAIN: crush_cfg.bits_mod_gain = $signed(data);
            default:           ;
        endcase
    endtask

    // Reprogram all four registers once the block is idle; unused upper bits get junk
    task automatic load_config(input cfg_t c);
        wait_drained();
        write_reg(CFG_RATE_FRACTION, {1'($urandom), c.rate_fraction});
        write_reg(CFG_RATE_MOD_GAIN, c.rate_mod_gain);
        write_reg(CFG_BIT_DEPTH, {13'($urandom), c.bit_depth});
        write_reg(CFG_BITS_MOD_GAIN, c.bits_mod_gain);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [17:0] rand_gain();
        case ($urandom_range(6))
            0:       return 18'sd0;
            1:       return 18'sd65536;
            2:       return -18'sd65536;
            3:       return 18'sh20000;
            4:       return 18'sh1FFFF;
            default: return 18'($urandom);
        endcase
    endfunction

    function automatic cfg_t rand_config();
        cfg_t c;
        case ($urandom_range(4))
            0:       c.rate_fraction = 17'd0;
            1:       c.rate_fraction = 17'd65536;
            2:       c.rate_fraction = 17'h1FFFF;
            3:       c.rate_fraction = 17'($urandom);
            default: c.rate_fraction = 17'($urandom_range(4096, 65536));
        endcase
        c.rate_mod_gain = rand_gain();
        case ($urandom_range(4))
            0:       c.bit_depth = 5'd0;
            1:       c.bit_depth = 5'd1;
            2:       c.bit_depth = 5'd24;
            3:       c.bit_depth = 5'd31;
            default: c.bit_depth = 5'($urandom_range(31));
        endcase
        c.bits_mod_gain = rand_gain();
        return c;
    endfunction

    // Control voltage: mostly within a volt or sixteen, sometimes full scale
    function automatic logic [31:0] rand_cv();
        case ($urandom_range(6))
            0:       return $urandom;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'($urandom_range(32'h1FFF_FFFF)) - 32'h1000_0000;
            default: return 32'($urandom_range(32'h01FF_FFFF)) - 32'h0100_0000;
        endcase
    endfunction

    // Reset values: first item lands exactly on 1.0 and must not latch
    task automatic test_reset_defaults();
        send_item(3'd0, 32'h1234_5678, 32'h0, 32'h0);
        send_item(3'd0, 32'h7FFF_FFFF, 32'h0, 32'h0);
        send_item(3'd7, 32'h8000_0000, 32'h0, 32'h0);
        send_item(3'd3, 32'hFFFF_FFFF, 32'h0, 32'h0);
        send_item(3'd0, 32'h0000_0000, 32'h0, 32'h0);
    endtask

    // Depth register and modulation pushed beyond 1..24 both ways
    task automatic test_depth_limits();
        load_config('{17'd65536, 18'sd0, 5'd0, 18'sd0});
        send_item(3'd1, 32'h5A5A_A5A5, 32'h0, 32'h0);
        send_item(3'd2, 32'hA5A5_5A5A, 32'h0, 32'h0);
        load_config('{17'd65536, 18'sd0, 5'd31, 18'sd0});
        send_item(3'd4, 32'h7FFF_FFFF, 32'h0, 32'h0);
        load_config('{17'd65536, 18'sd0, 5'd24, 18'sh1FFFF});
        send_item(3'd5, 32'h0123_4567, 32'h0, 32'h8000_0000);
        send_item(3'd6, 32'hFEDC_BA98, 32'h0, 32'h7FFF_FFFF);
        load_config('{17'd65536, 18'sd0, 5'd1, 18'sh20000});
        send_item(3'd6, 32'h8765_4321, 32'h0, 32'h8000_0000);
    endtask

    // Phase counter clamped at zero, saturated at the top, then free-running wraps
    task automatic test_counter_limits();
        load_config('{17'd0, 18'sh1FFFF, 5'd12, 18'sd0});
        send_item(3'd1, 32'h1111_1111, 32'h8000_0000, 32'h0);
        send_item(3'd1, 32'h2222_2222, 32'h7FFF_FFFF, 32'h0);
        send_item(3'd2, 32'h3333_3333, 32'h7FFF_FFFF, 32'h0);
        send_item(3'd2, 32'h4444_4444, 32'h0, 32'h0);
        send_item(3'd3, 32'hCCCC_CCCC, 32'hF000_0000, 32'h0);
        send_item(3'd3, 32'hDDDD_DDDD, 32'h8000_0000, 32'h0);
    endtask

    // Random items in four handshake phases, reprogrammed every hundred items
    task automatic test_random_traffic();
        logic [31:0] smp;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            for (int blk = 0; blk < 4; blk++)
            begin
                load_config(rand_config());
                for (int n = 0; n < 100; n++)
                begin
                    case ($urandom_range(15))
                        0:       smp = 32'h7FFF_FFFF;
                        1:       smp = 32'h8000_0000;
                        2:       smp = 32'hFFFF_FFFF;
                        default: smp = $urandom;
                    endcase
                    send_item(3'($urandom_range(7)), smp, rand_cv(), rand_cv());
                    if ($urandom_range(199) == 0)
                        wait_drained();
                end
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Check each result item as it leaves and pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (crushed_queue.size() == 0)
                    note_bad("result with nothing due", 'x, sample_out);
                else
                begin
                    due_sample = crushed_queue.pop_front();
                    if (sample_out !== due_sample)
                        note_bad("sample_out mismatch", due_sample, sample_out);
                end
            end
            out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        crush_cfg = '{17'd65536, 18'sd0, 5'd24, 18'sd0};
        phase_acc = '0;
        for (int i = 0; i < VOICES_DEF; i++)
            held_store[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_depth_limits();
        test_counter_limits();
        test_random_traffic();

        // Drain with a bound, then allow for the pipeline depth
        in_valid <= 1'b0;
        for (int n = 0; n < 5000 && crushed_queue.size() != 0; n++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (crushed_queue.size() != 0)
        begin
            bad_results += crushed_queue.size();
            $display("%0d result items never arrived", crushed_queue.size());
        end
        if (bad_results == 0)
            $display("audio_bit_crusher_unit_tb: PASS");
        else
            $display("audio_bit_crusher_unit_tb: FAIL");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("audio_bit_crusher_unit_tb: FAIL");
        $finish;
    end

endmodule
